[rtl/bfm_pkg.sv]
// bfm_pkg: shared types and constants of the bloom filter engine
// holds the hash constants, the job record passed front to back, and the back-end states
// no dependencies
package bfm_pkg;

  // key length counter width, covers keys up to 2047 bytes
  localparam int KLEN_W = 11;

  // murmur3 x86_32 constants
  localparam logic [31:0] SEED0   = 32'h9747b28c;
  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

  // operation codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // register indexes
  localparam logic [7:0] REG_BIT_COUNT  = 8'd0;
  localparam logic [7:0] REG_HASH_COUNT = 8'd1;

  typedef logic [KLEN_W-1:0] klen_t;

  // one finished key handed to the back end
  typedef struct packed {
    logic        func;
    logic        ovf;
    klen_t       len;
    logic [31:0] tail;
  } job_t;

  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_RD,
    BS_K1,
    BS_K2,
    BS_MIX,
    BS_FIN0,
    BS_FIN1,
    BS_FIN2,
    BS_DIV,
    BS_PROBE,
    BS_CHK,
    BS_DONE
  } bstate_t;

endpackage

[rtl/bloom_filter_murmur3.sv]
// bloom_filter_murmur3: top level, config registers and wiring of front, queue and back
// depends on bfm_pkg, bfm_front, bfm_queue, bfm_back
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_func, in_key_word, in_byte_count, in_last
// out     | output    | out_valid / out_stall| out_present, out_status
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word per cycle unless stalled; a last word stalls the input until its result is built
// a hash pass runs RD, K1, K2, MIX per full word, K1, K2, MIX for a tail, then FIN0 to FIN2
// a probe runs DIV steps of the 4-bit-per-cycle modulo unit, then PROBE and for a query CHK
// after reset all MAX_BITS filter bits are cleared one bit a cycle, input stalled
// the result register lets the back end run the next key while a result waits on out_stall
module bloom_filter_murmur3 #(
  parameter int MAX_BITS = 65536,
  parameter int MAX_HASHES = 16,
  parameter int MAX_KEY_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_key_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_present,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import bfm_pkg::*;

  localparam int KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;
  localparam int KAW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int MW  = $clog2(MAX_BITS + 1);
  localparam int PW  = $clog2(MAX_HASHES + 1);

  logic [16:0] bit_count_r, bit_count_nxt;
  logic [4:0]  hash_count_r, hash_count_nxt;
  logic [31:0] bc32, mod32, hc32, pr32;

  logic           push, pop, q_valid, done, clearing;
  job_t           job_in, job_q;
  logic [KAW-1:0] rd_addr;
  logic [31:0]    rd_data;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_comb begin
    bit_count_nxt  = bit_count_r;
    hash_count_nxt = hash_count_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_BIT_COUNT:  bit_count_nxt  = cfg_data;
        REG_HASH_COUNT: hash_count_nxt = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= 17'h10000;
      hash_count_r <= 5'd7;
    end else begin
      bit_count_r  <= bit_count_nxt;
      hash_count_r <= hash_count_nxt;
    end
  end

  // range clamps of the effective modulus and probe count
  always_comb begin
    bc32  = {15'b0, bit_count_r};
    mod32 = (bc32 < 32'd64) ? 32'd64 : ((bc32 > 32'(MAX_BITS)) ? 32'(MAX_BITS) : bc32);
    hc32  = {27'b0, hash_count_r};
    pr32  = (hc32 == 32'd0) ? 32'd1 :
            ((hc32 > 32'(MAX_HASHES)) ? 32'(MAX_HASHES) : hc32);
  end

  bfm_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .KAW(KAW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .hold_i(clearing),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_key_word(in_key_word),
    .in_byte_count(in_byte_count),
    .in_last(in_last),
    .push_o(push),
    .job_o(job_in),
    .done_i(done),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  bfm_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_i(push),
    .job_i(job_in),
    .pop_i(pop),
    .valid_o(q_valid),
    .job_o(job_q)
  );

  bfm_back #(
    .MAX_BITS(MAX_BITS),
    .MW(MW),
    .PW(PW),
    .KAW(KAW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .modulus_i(mod32[MW-1:0]),
    .probes_i(pr32[PW-1:0]),
    .q_valid_i(q_valid),
    .q_job_i(job_q),
    .q_pop_o(pop),
    .done_o(done),
    .clearing_o(clearing),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_present(out_present),
    .out_status(out_status)
  );

endmodule

[rtl/bfm_front.sv]
// bfm_front: accepts key words, packs bytes into the key memory, hands a job on the last word
// depends on bfm_pkg
module bfm_front #(
  parameter int MAX_KEY_BYTES = 64,
  parameter int KAW = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            hold_i,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_func,
  input  logic [31:0]     in_key_word,
  input  logic [2:0]      in_byte_count,
  input  logic            in_last,
  output logic            push_o,
  output bfm_pkg::job_t   job_o,
  input  logic            done_i,
  input  logic [KAW-1:0]  rd_addr_i,
  output logic [31:0]     rd_data_o
);
  import bfm_pkg::*;

  localparam int KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;

  logic [31:0] kmem [KEY_WORDS];
  logic [31:0] rd_data_r;

  klen_t       len_r, len_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic        busy_r, busy_nxt;

  logic              acc;
  logic [2:0]        cnt;
  logic [31:0]       mask, wm;
  logic [63:0]       comb;
  logic [3:0]        total;
  logic [KLEN_W:0]   sum;
  logic              fits;
  logic              wr_en;
  logic [KAW-1:0]    wr_addr;

  assign in_stall = busy_r | hold_i;
  assign acc      = in_valid & ~in_stall;

  // byte count clamp and byte mask
  always_comb begin
    cnt = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    case (cnt)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  // append new bytes behind the pending partial word
  always_comb begin
    wm    = in_key_word & mask;
    comb  = {32'b0, pend_r} | ({32'b0, wm} << {len_r[1:0], 3'b000});
    total = {2'b0, len_r[1:0]} + {1'b0, cnt};
    sum   = {1'b0, len_r} + {{(KLEN_W-2){1'b0}}, cnt};
    fits  = sum <= (KLEN_W+1)'(MAX_KEY_BYTES);
    wr_addr = len_r[KAW+1:2];
  end

  // front control
  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    pend_nxt = pend_r;
    busy_nxt = busy_r;
    wr_en    = 1'b0;
    push_o   = 1'b0;
    if (done_i) begin
      busy_nxt = 1'b0;
    end
    if (acc) begin
      if (!ovf_r) begin
        if (!fits) begin
          ovf_nxt = 1'b1;
        end else begin
          len_nxt = sum[KLEN_W-1:0];
          if (total[2]) begin
            wr_en    = 1'b1;
            pend_nxt = comb[63:32];
          end else begin
            pend_nxt = comb[31:0];
          end
        end
      end
      if (in_last) begin
        push_o   = 1'b1;
        busy_nxt = 1'b1;
        len_nxt  = '0;
        ovf_nxt  = 1'b0;
        pend_nxt = '0;
      end
    end
  end

  // job record reflects this transaction's update
  always_comb begin
    job_o.func = in_func;
    job_o.ovf  = ovf_r | ~fits;
    job_o.len  = (ovf_r | ~fits) ? len_r : sum[KLEN_W-1:0];
    job_o.tail = (ovf_r | ~fits) ? pend_r : (total[2] ? comb[63:32] : comb[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      pend_r <= '0;
      busy_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      pend_r <= pend_nxt;
      busy_r <= busy_nxt;
    end
  end

  // key word memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      kmem[wr_addr] <= comb[31:0];
    end
    rd_data_r <= kmem[rd_addr_i];
  end

  assign rd_data_o = rd_data_r;

endmodule

[rtl/bfm_queue.sv]
// bfm_queue: two-entry job queue between front and back
// depends on bfm_pkg
module bfm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  bfm_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output bfm_pkg::job_t job_o
);
  import bfm_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign valid_o = cnt_r != 2'd0;
  assign job_o   = ent_r[rp_r];
  assign do_pop  = pop_i & valid_o;

  // pointer and fill update
  always_comb begin
    wp_nxt  = push_i ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wp_r] <= job_i;
    end
  end

endmodule

[rtl/bfm_back.sv]
// bfm_back: two murmur3 passes, probe position modulo, filter memory and result register
// depends on bfm_pkg
module bfm_back #(
  parameter int MAX_BITS = 65536,
  parameter int MW = 17,
  parameter int PW = 5,
  parameter int KAW = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [MW-1:0]   modulus_i,
  input  logic [PW-1:0]   probes_i,
  input  logic            q_valid_i,
  input  bfm_pkg::job_t   q_job_i,
  output logic            q_pop_o,
  output logic            done_o,
  output logic            clearing_o,
  output logic [KAW-1:0]  rd_addr_o,
  input  logic [31:0]     rd_data_i,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_present,
  output logic            out_status
);
  import bfm_pkg::*;

  localparam int IW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int BW = KLEN_W - 2;

  logic fmem [MAX_BITS];
  logic fmem_rd_r;

  bstate_t state_r, state_nxt;

  job_t           job_r, job_nxt;
  logic [31:0]    h_r, h_nxt, t_r, t_nxt, h1_r, h1_nxt, h2_r, h2_nxt;
  logic [31:0]    pos_r, pos_nxt, d_r, d_nxt;
  logic [MW-1:0]  r_r, r_nxt;
  logic [2:0]     dcnt_r, dcnt_nxt;
  logic [PW-1:0]  i_r, i_nxt;
  logic [BW-1:0]  blk_r, blk_nxt;
  logic           pass_r, pass_nxt, tail_r, tail_nxt, all_r, all_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  logic           ov_r, ov_nxt, op_r, op_nxt, os_r, os_nxt;

  logic [BW-1:0]  nblk;
  logic           has_tail, last_blk, last_probe, out_free;
  logic [31:0]    kop, hx, rot, mixed;
  logic [MW:0]    tmp;
  logic [31:0]    dsh;
  logic [MW-1:0]  rdiv;
  logic           f_we, f_wd;
  logic [IW-1:0]  f_addr;

  assign nblk       = job_r.len[KLEN_W-1:2];
  assign has_tail   = job_r.len[1:0] != 2'b00;
  assign last_blk   = (blk_r + BW'(1)) == nblk;
  assign last_probe = ({1'b0, i_r} + (PW+1)'(1)) == {1'b0, probes_i};
  assign out_free   = ~ov_r | ~out_stall;
  assign clearing_o = state_r == BS_CLEAR;
  assign rd_addr_o  = blk_r[KAW-1:0];
  assign out_valid  = ov_r;
  assign out_present = op_r;
  assign out_status  = os_r;

  // four remainder steps of the probe modulo
  always_comb begin
    rdiv = r_r;
    dsh  = d_r;
    tmp  = '0;
    for (int j = 0; j < 4; j++) begin
      tmp = {rdiv, dsh[31]};
      if (tmp >= {1'b0, modulus_i}) begin
        tmp = tmp - {1'b0, modulus_i};
      end
      rdiv = tmp[MW-1:0];
      dsh  = {dsh[30:0], 1'b0};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_CLEAR: if (clr_r == IW'(MAX_BITS - 1)) state_nxt = BS_IDLE;
      BS_IDLE: begin
        if (q_valid_i) begin
          if (q_job_i.ovf) begin
            state_nxt = BS_DONE;
          end else if (q_job_i.len[KLEN_W-1:2] != '0) begin
            state_nxt = BS_RD;
          end else if (q_job_i.len[1:0] != 2'b00) begin
            state_nxt = BS_K1;
          end else begin
            state_nxt = BS_FIN0;
          end
        end
      end
      BS_RD:  state_nxt = BS_K1;
      BS_K1:  state_nxt = BS_K2;
      BS_K2:  state_nxt = BS_MIX;
      BS_MIX: begin
        if (tail_r) begin
          state_nxt = BS_FIN0;
        end else if (!last_blk) begin
          state_nxt = BS_RD;
        end else if (has_tail) begin
          state_nxt = BS_K1;
        end else begin
          state_nxt = BS_FIN0;
        end
      end
      BS_FIN0: state_nxt = BS_FIN1;
      BS_FIN1: state_nxt = BS_FIN2;
      BS_FIN2: begin
        if (!pass_r) begin
          if (nblk != '0) begin
            state_nxt = BS_RD;
          end else if (has_tail) begin
            state_nxt = BS_K1;
          end else begin
            state_nxt = BS_FIN0;
          end
        end else begin
          state_nxt = BS_DIV;
        end
      end
      BS_DIV:   if (dcnt_r == 3'd7) state_nxt = BS_PROBE;
      BS_PROBE: begin
        if (job_r.func == FUNC_QUERY) begin
          state_nxt = BS_CHK;
        end else begin
          state_nxt = last_probe ? BS_DONE : BS_DIV;
        end
      end
      BS_CHK:  state_nxt = last_probe ? BS_DONE : BS_DIV;
      BS_DONE: if (out_free) state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_nxt  = job_r;
    h_nxt    = h_r;
    t_nxt    = t_r;
    h1_nxt   = h1_r;
    h2_nxt   = h2_r;
    pos_nxt  = pos_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    dcnt_nxt = dcnt_r;
    i_nxt    = i_r;
    blk_nxt  = blk_r;
    pass_nxt = pass_r;
    tail_nxt = tail_r;
    all_nxt  = all_r;
    clr_nxt  = clr_r;
    ov_nxt   = ov_r & out_stall;
    op_nxt   = op_r;
    os_nxt   = os_r;
    q_pop_o  = 1'b0;
    done_o   = 1'b0;
    f_we     = 1'b0;
    f_wd     = 1'b0;
    f_addr   = r_r[IW-1:0];
    kop      = tail_r ? job_r.tail : rd_data_i;
    hx       = h_r ^ t_r;
    rot      = {hx[18:0], hx[31:19]};
    mixed    = (rot << 2) + rot + MIX_ADD;

    case (state_r)
      BS_CLEAR: begin
        f_we    = 1'b1;
        f_addr  = clr_r;
        clr_nxt = clr_r + IW'(1);
      end
      BS_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          job_nxt  = q_job_i;
          h_nxt    = SEED0;
          blk_nxt  = '0;
          pass_nxt = 1'b0;
          tail_nxt = q_job_i.len[KLEN_W-1:2] == '0;
        end
      end
      BS_K1: t_nxt = kop * MIX_C1;
      BS_K2: t_nxt = {t_r[16:0], t_r[31:17]} * MIX_C2;
      BS_MIX: begin
        if (tail_r) begin
          h_nxt = hx;
        end else begin
          h_nxt   = mixed;
          blk_nxt = blk_r + BW'(1);
          if (last_blk) tail_nxt = 1'b1;
        end
      end
      BS_FIN0: begin
        hx    = h_r ^ {{(32-KLEN_W){1'b0}}, job_r.len};
        hx    = hx ^ (hx >> 16);
        h_nxt = hx * FIN_C1;
      end
      BS_FIN1: begin
        hx    = h_r ^ (h_r >> 13);
        h_nxt = hx * FIN_C2;
      end
      BS_FIN2: begin
        hx = h_r ^ (h_r >> 16);
        if (!pass_r) begin
          h1_nxt   = hx;
          h_nxt    = hx;
          pass_nxt = 1'b1;
          blk_nxt  = '0;
          tail_nxt = nblk == '0;
        end else begin
          h2_nxt   = hx;
          pos_nxt  = h1_r;
          d_nxt    = h1_r;
          r_nxt    = '0;
          dcnt_nxt = '0;
          i_nxt    = '0;
          all_nxt  = 1'b1;
        end
      end
      BS_DIV: begin
        r_nxt    = rdiv;
        d_nxt    = dsh;
        dcnt_nxt = dcnt_r + 3'd1;
      end
      BS_PROBE: begin
        if (job_r.func == FUNC_ADD) begin
          f_we     = 1'b1;
          f_wd     = 1'b1;
          pos_nxt  = pos_r + h2_r;
          d_nxt    = pos_r + h2_r;
          r_nxt    = '0;
          dcnt_nxt = '0;
          i_nxt    = i_r + PW'(1);
        end
      end
      BS_CHK: begin
        if (!fmem_rd_r) all_nxt = 1'b0;
        pos_nxt  = pos_r + h2_r;
        d_nxt    = pos_r + h2_r;
        r_nxt    = '0;
        dcnt_nxt = '0;
        i_nxt    = i_r + PW'(1);
      end
      BS_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          os_nxt = job_r.ovf;
          op_nxt = ~job_r.ovf & (job_r.func == FUNC_QUERY) & all_r;
          done_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    h_r    <= h_nxt;
    t_r    <= t_nxt;
    h1_r   <= h1_nxt;
    h2_r   <= h2_nxt;
    pos_r  <= pos_nxt;
    d_r    <= d_nxt;
    r_r    <= r_nxt;
    dcnt_r <= dcnt_nxt;
    i_r    <= i_nxt;
    blk_r  <= blk_nxt;
    pass_r <= pass_nxt;
    tail_r <= tail_nxt;
    all_r  <= all_nxt;
    op_r   <= op_nxt;
    os_r   <= os_nxt;
  end

  // filter bit memory
  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_addr] <= f_wd;
    end
    fmem_rd_r <= fmem[f_addr];
  end

endmodule
